// File: src/fat12_pkg.sv
package fat12_pkg;

    localparam int TABLE_BYTES = 8192;
    localparam int MAX_CHAIN   = 64;

    localparam int TABLE_AW  = $clog2(TABLE_BYTES);
    localparam int BANK_AW   = TABLE_AW - 1;
    localparam int BANK_DEPTH = TABLE_BYTES / 2;
    localparam int ADDR_W    = 13;
    localparam int WA_W      = (TABLE_AW > ADDR_W) ? TABLE_AW : ADDR_W;
    localparam int IDX_W     = (TABLE_AW >= 14) ? TABLE_AW + 1 : 14;
    localparam int CNT_W     = $clog2(MAX_CHAIN + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RESERVED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_SECT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_COPIES = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROOT_ENTRIES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SECT_LOG2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SECT_CLUSTER = 3'd5;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_WALK  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BELOW_TWO = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;
    localparam logic [1:0] ST_OUT_TABLE = 2'd3;

    localparam logic [11:0] CLUSTER_MASK = 12'hFFF;
    localparam logic [11:0] END_OF_CHAIN = 12'hFF8;
    localparam logic [11:0] FIRST_DATA   = 12'd2;

    typedef struct packed {
        logic write;
        logic start;
        logic read;
        logic eval;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic final_item;
    } t_dp_sts;

endpackage

// File: src/fat12_ifs.sv
interface fat12_item_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [12:0] table_address;
    logic [7:0]  table_byte;
    logic [11:0] start_cluster;

    modport source (output valid, command, table_address, table_byte, start_cluster,
                    input ready);
    modport sink (input valid, command, table_address, table_byte, start_cluster,
                  output ready);
endinterface

interface fat12_result_if;
    logic        valid;
    logic        ready;
    logic [11:0] cluster_number;
    logic [31:0] cluster_lba;
    logic [1:0]  status;
    logic        last_of_chain;

    modport source (output valid, cluster_number, cluster_lba, status, last_of_chain,
                    input ready);
    modport sink (input valid, cluster_number, cluster_lba, status, last_of_chain,
                  output ready);
endinterface

interface fat12_cfg_if;
    import fat12_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: src/fat12_ctrl.sv
module fat12_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_command,
    output logic               o_in_ready,
    output fat12_pkg::t_dp_cmd o_cmd,
    input  fat12_pkg::t_dp_sts i_sts
);
    import fat12_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_command == CMD_WALK) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_READ;
                    end else begin
                        o_cmd.write = 1'b1;
                    end
                end
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_EVAL;
            end
            S_EVAL: begin
                if (i_sts.out_free) begin
                    o_cmd.eval = 1'b1;
                    n_state    = i_sts.final_item ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/fat12_dp.sv
module fat12_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  fat12_pkg::t_dp_cmd               i_cmd,
    output fat12_pkg::t_dp_sts               o_sts,
    input  logic [12:0]                      i_table_address,
    input  logic [7:0]                       i_table_byte,
    input  logic [11:0]                      i_start_cluster,
    input  logic                             i_cfg_valid,
    input  logic [fat12_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fat12_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                             o_cfg_ready,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [11:0]                      o_cluster_number,
    output logic [31:0]                      o_cluster_lba,
    output logic [1:0]                       o_status,
    output logic                             o_last_of_chain
);
    import fat12_pkg::*;

    // configuration registers
    logic [15:0] r_reserved;
    logic [15:0] r_table_sect;
    logic [2:0]  r_copies;
    logic [15:0] r_root_entries;
    logic [3:0]  r_sect_log2;
    logic [7:0]  r_sect_cluster;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reserved     <= 16'd1;
            r_table_sect   <= 16'd9;
            r_copies       <= 3'd2;
            r_root_entries <= 16'd224;
            r_sect_log2    <= 4'd9;
            r_sect_cluster <= 8'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RESERVED:     r_reserved     <= i_cfg_data;
                REG_TABLE_SECT:   r_table_sect   <= i_cfg_data;
                REG_TABLE_COPIES: r_copies       <= i_cfg_data[2:0];
                REG_ROOT_ENTRIES: r_root_entries <= i_cfg_data;
                REG_SECT_LOG2:    r_sect_log2    <= i_cfg_data[3:0];
                REG_SECT_CLUSTER: r_sect_cluster <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // data region start
    logic [20:0] dir_bytes;
    logic [21:0] unit_m1;
    logic [21:0] dir_sum;
    logic [21:0] dir_sectors;
    logic [18:0] table_sectors;
    logic [31:0] data_start;

    always_comb begin
        dir_bytes     = {r_root_entries, 5'b0};
        unit_m1       = (22'd1 << r_sect_log2) - 22'd1;
        dir_sum       = 22'(dir_bytes) + unit_m1;
        dir_sectors   = dir_sum >> r_sect_log2;
        table_sectors = 19'(r_table_sect) * 19'(r_copies);
        data_start    = 32'(r_reserved) + 32'(table_sectors) + 32'(dir_sectors);
    end

    // table banks, even and odd bytes
    logic [7:0] mem_even [BANK_DEPTH];
    logic [7:0] mem_odd  [BANK_DEPTH];
    logic [7:0] r_even_q;
    logic [7:0] r_odd_q;

    logic [WA_W-1:0] wr_addr;
    logic            wr_in_range;

    assign wr_addr     = WA_W'(i_table_address);
    assign wr_in_range = 32'(wr_addr) < 32'(TABLE_BYTES);

    // walk datapath
    logic [11:0]      r_cur;
    logic [CNT_W-1:0] r_count;
    logic [31:0]      r_data_start;
    logic [31:0]      r_lba;
    logic             r_below2;
    logic             r_oor;
    logic             r_idx_odd;

    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] idx1;
    logic [11:0]      diff;
    logic [19:0]      prod;

    always_comb begin
        idx  = IDX_W'(r_cur) + IDX_W'(r_cur[11:1]);
        idx1 = idx + IDX_W'(1);
        diff = r_cur - FIRST_DATA;
        prod = 20'(diff) * 20'(r_sect_cluster);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && wr_in_range) begin
            if (wr_addr[0]) begin
                mem_odd[wr_addr[TABLE_AW-1:1]] <= i_table_byte;
            end else begin
                mem_even[wr_addr[TABLE_AW-1:1]] <= i_table_byte;
            end
        end
        if (i_cmd.read) begin
            r_odd_q  <= mem_odd[idx[BANK_AW:1]];
            r_even_q <= mem_even[idx1[BANK_AW:1]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_data_start <= data_start;
        end
        if (i_cmd.read) begin
            r_lba     <= r_data_start + 32'(prod);
            r_below2  <= r_cur < FIRST_DATA;
            r_oor     <= 32'(idx1) >= 32'(TABLE_BYTES);
            r_idx_odd <= idx[0];
        end
    end

    // decode of the next entry
    logic [15:0]      pair;
    logic [11:0]      next;
    logic [CNT_W-1:0] count1;
    logic             at_end;
    logic             too_long;
    logic [1:0]       status;
    logic             final_item;

    always_comb begin
        pair       = r_idx_odd ? {r_even_q, r_odd_q} : {r_odd_q, r_even_q};
        next       = (r_cur[0] ? pair[15:4] : pair[11:0]) & CLUSTER_MASK;
        count1     = r_count + CNT_W'(1);
        at_end     = next >= END_OF_CHAIN;
        too_long   = count1 == CNT_W'(MAX_CHAIN);
        final_item = r_below2 || r_oor || at_end || too_long;
        if (r_below2) begin
            status = ST_BELOW_TWO;
        end else if (r_oor) begin
            status = ST_OUT_TABLE;
        end else if (!at_end && too_long) begin
            status = ST_TOO_LONG;
        end else begin
            status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_count <= '0;
        end else if (i_cmd.start) begin
            r_cur   <= i_start_cluster;
            r_count <= '0;
        end else if (i_cmd.eval && !final_item) begin
            r_cur   <= next;
            r_count <= count1;
        end
    end

    // result register
    logic        r_out_valid;
    logic [11:0] r_out_cluster;
    logic [31:0] r_out_lba;
    logic [1:0]  r_out_status;
    logic        r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.eval) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_out_cluster <= r_cur;
            r_out_lba     <= r_below2 ? '0 : r_lba;
            r_out_status  <= status;
            r_out_last    <= final_item;
        end
    end

    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_sts.final_item = final_item;

    assign o_out_valid      = r_out_valid;
    assign o_cluster_number = r_out_cluster;
    assign o_cluster_lba    = r_out_lba;
    assign o_status         = r_out_status;
    assign o_last_of_chain  = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_CHAIN))
        else $error("chain count past limit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval |-> (!r_out_valid || i_out_ready))
        else $error("pending result overwritten");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval && status != ST_OK |=> r_out_last)
        else $error("error result not last");

    a_below_two_lba: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval && r_below2 |=> r_out_lba == '0 && r_out_status == ST_BELOW_TWO)
        else $error("below-two result malformed");

endmodule

// File: src/fat12_cluster_chain_walker.sv
// FAT12 cluster chain walker. Request on i_item with command 0 writes one byte of the
// allocation table (no result); command 1 starts a walk from start_cluster and
// yields one result per cluster on o_result, the final one flagged by last_of_chain.
// A walk is accepted while idle; then for each cluster the two-byte entry is read,
// registered, from the even and odd table banks, then decoded and loaded into the
// result register. A full result register stalls the walk until it is taken.
// No other request is taken while a walk runs. Registers on i_cfg take effect at once
// and are to be written only while no walk is in progress. Table bytes never written
// read back as undefined.
module fat12_cluster_chain_walker (
    input logic           i_clk,
    input logic           i_rst_n,
    fat12_item_if.sink    i_item,
    fat12_result_if.source o_result,
    fat12_cfg_if.sink     i_cfg
);
    import fat12_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    fat12_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_item.valid),
        .i_in_command (i_item.command),
        .o_in_ready   (i_item.ready),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    fat12_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_table_address  (i_item.table_address),
        .i_table_byte     (i_item.table_byte),
        .i_start_cluster  (i_item.start_cluster),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .o_cfg_ready      (i_cfg.ready),
        .o_out_valid      (o_result.valid),
        .i_out_ready      (o_result.ready),
        .o_cluster_number (o_result.cluster_number),
        .o_cluster_lba    (o_result.cluster_lba),
        .o_status         (o_result.status),
        .o_last_of_chain  (o_result.last_of_chain)
    );

endmodule
